### design/cswl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cswl_pkg
// shared types and constants of the column sprite list walker
// ---------------------------------------------------------------------------
package cswl_pkg;

  localparam int RAM_BYTES = 8192;
  localparam int ADDR_W    = $clog2(RAM_BYTES);
  localparam int WADDR_W   = ADDR_W - 1;

  localparam logic [ADDR_W-1:0] LIST_START     = ADDR_W'(13'h1500);
  localparam logic [ADDR_W-1:0] LIST_GAP_START = ADDR_W'(13'h1800);
  localparam logic [ADDR_W-1:0] LIST_GAP_END   = ADDR_W'(13'h1980);
  localparam logic [ADDR_W-1:0] LIST_END       = ADDR_W'(13'h19c0);

  localparam logic [7:0] COLUMN_STEP = 8'd16;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_SLOT  = 2'd1,
    ACT_FRAME = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic {
    CFG_LAYOUT_MODE = 1'b0,
    CFG_CHAR_BANK   = 1'b1
  } cfg_index_t;

  // one request per cycle to the byte-lane ram
  typedef struct packed {
    logic               we;
    logic               wlane;
    logic [WADDR_W-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [WADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

### design/cswl_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cswl_ram
// object ram as two byte lanes, byte writes, 16-bit registered word reads
// ---------------------------------------------------------------------------
module cswl_ram (
  input  logic              clk,
  input  cswl_pkg::ram_req_t req,
  output logic [7:0]        rd_lo,
  output logic [7:0]        rd_hi
);

  localparam int DEPTH = cswl_pkg::RAM_BYTES / 2;

  logic [7:0] mem_lo [DEPTH];
  logic [7:0] mem_hi [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we && !req.wlane) begin
      mem_lo[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_lo <= mem_lo[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.we && req.wlane) begin
      mem_hi[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_hi <= mem_hi[req.raddr];
    end
  end

endmodule

### design/cswl_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cswl_ctrl
// sequencer: ram writes, entry header fetch, tile word fetch and output word
// ---------------------------------------------------------------------------
module cswl_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   action,
  input  logic [cswl_pkg::ADDR_W-1:0]  address,
  input  logic [7:0]                   write_data,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [7:0]                   cfg_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [12:0]                  tile_code,
  output logic [3:0]                   palette,
  output logic                         flip_x,
  output logic [7:0]                   pos_x,
  output logic [7:0]                   pos_y,
  output logic                         last,
  output cswl_pkg::ram_req_t           ram_req,
  input  logic [7:0]                   rd_lo,
  input  logic [7:0]                   rd_hi
);

  localparam int WW = cswl_pkg::WADDR_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HDR0,
    S_HDR1,
    S_OUT
  } state_t;

  typedef struct packed {
    logic       h;
    logic [4:0] r;
  } tile_pos_t;

  state_t          state;
  logic            layout_mode;
  logic            char_bank;
  logic [7:0]      column_x;
  logic [WW-2:0]   entry_addr;
  logic [7:0]      b0;
  logic [7:0]      g;
  logic            attr_pal;
  logic [7:0]      sy;
  logic [5:0]      k;

  logic            accept;
  logic            in_range;
  logic            tall;
  logic [11:0]     base_w;
  logic [5:0]      last_idx;
  logic [5:0]      k_fetch;
  tile_pos_t       pos_fetch;
  tile_pos_t       pos_cur;
  logic [11:0]     tile_addr;
  logic            entry_empty;
  logic            entry_skip;
  logic            load;

  function automatic tile_pos_t tile_pos(input logic [5:0] kk, input logic is_tall,
                                         input logic mode);
    tile_pos_t p;
    if (mode) begin
      p.h = kk[0];
      p.r = kk[5:1];
    end else if (is_tall) begin
      p.h = kk[5];
      p.r = kk[4:0];
    end else begin
      p.h = kk[1];
      p.r = {4'd0, kk[0]};
    end
    return p;
  endfunction

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    in_range = (address >= cswl_pkg::LIST_START);
    if (layout_mode) begin
      in_range = in_range && (address < cswl_pkg::LIST_GAP_START);
    end else begin
      in_range = in_range && (address < cswl_pkg::LIST_END) &&
                 !((address >= cswl_pkg::LIST_GAP_START) &&
                   (address < cswl_pkg::LIST_GAP_END));
    end
  end

  assign tall     = g[7];
  assign last_idx = tall ? 6'd63 : 6'd3;

  always_comb begin
    if (tall) begin
      base_w = {g[5:0], 6'd0};
    end else begin
      base_w = {1'b0, g[4:0], 6'd0} + {7'd0, g[6:5], 3'd0} + 12'd6;
    end
  end

  assign k_fetch   = (state == S_HDR1) ? 6'd0 : k + 6'd1;
  assign pos_fetch = tile_pos(k_fetch, tall, layout_mode);
  assign pos_cur   = tile_pos(k, tall, layout_mode);
  assign tile_addr = base_w + (pos_fetch.h ? 12'h020 : 12'h000) + {7'd0, pos_fetch.r};

  assign entry_empty = ((b0 | g | rd_lo | rd_hi) == 8'd0);
  assign entry_skip  = entry_empty || (layout_mode && !g[7] && (b0 == 8'd0 || rd_lo == 8'd0));

  assign load = (state == S_OUT) && (!out_valid || !out_stall);

  always_comb begin
    ram_req       = '0;
    ram_req.wlane = address[0];
    ram_req.waddr = address[cswl_pkg::ADDR_W-1:1];
    ram_req.wdata = write_data;
    ram_req.raddr = {address[cswl_pkg::ADDR_W-1:2], 1'b0};
    case (state)
      S_IDLE: begin
        ram_req.we = accept && (action == cswl_pkg::ACT_WRITE);
        ram_req.re = accept && (action == cswl_pkg::ACT_SLOT) && in_range;
      end
      S_HDR0: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = {entry_addr, 1'b1};
      end
      S_HDR1: begin
        ram_req.re    = !entry_skip;
        ram_req.raddr = WW'(tile_addr);
      end
      S_OUT: begin
        ram_req.re    = load && (k != last_idx);
        ram_req.raddr = WW'(tile_addr);
      end
      default: begin
        ram_req.re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      layout_mode <= 1'b0;
      char_bank   <= 1'b0;
      column_x    <= 8'd0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cswl_pkg::CFG_LAYOUT_MODE: layout_mode <= cfg_data[0];
          cswl_pkg::CFG_CHAR_BANK:   char_bank   <= cfg_data[0];
          default: ;
        endcase
      end
      out_valid <= load || (out_valid && out_stall);
      case (state)
        S_IDLE: begin
          if (accept) begin
            entry_addr <= address[cswl_pkg::ADDR_W-1:2];
            if (action == cswl_pkg::ACT_FRAME) begin
              column_x <= 8'd0;
            end
            if (action == cswl_pkg::ACT_SLOT && in_range) begin
              state <= S_HDR0;
            end
          end
        end
        S_HDR0: begin
          b0    <= rd_lo;
          g     <= rd_hi;
          state <= S_HDR1;
        end
        S_HDR1: begin
          if (entry_skip) begin
            state <= S_IDLE;
          end else begin
            attr_pal <= rd_hi[1];
            sy       <= (tall ? 8'd0 : 8'd240) - b0;
            k        <= 6'd0;
            if (g[7:6] == 2'b11) begin
              column_x <= column_x + cswl_pkg::COLUMN_STEP;
            end else begin
              column_x <= rd_lo;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (load) begin
            if (layout_mode) begin
              tile_code <= {rd_hi[4:0], rd_lo};
              palette   <= {1'b0, rd_hi[7:5]};
              flip_x    <= 1'b0;
            end else begin
              tile_code <= {char_bank, rd_hi[7], rd_hi[2:0], rd_lo};
              palette   <= {attr_pal, rd_hi[5:3]};
              flip_x    <= rd_hi[6];
            end
            pos_x <= column_x + {4'd0, pos_cur.h, 3'd0};
            pos_y <= sy + {pos_cur.r, 3'd0};
            last  <= (k == last_idx);
            if (k == last_idx) begin
              state <= S_IDLE;
            end else begin
              k <= k + 6'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_k_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (k <= last_idx))
    else $error("tile index beyond entry");

  a_out_from_fetch: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("output word not from tile fetch");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && out_stall) |=> $stable(k))
    else $error("tile index moved while output stalled");

  a_column_update: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(column_x)) |->
      ($past(state == S_HDR1) || $past(accept && action == cswl_pkg::ACT_FRAME)))
    else $error("column x changed outside header decode or frame start");

endmodule

### design/column_sprite_list_walker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// column_sprite_list_walker
// object-list walker of a sprite-only video chip with 8 KiB object ram
// ---------------------------------------------------------------------------
// input words (in_valid / in_stall): action selects a ram byte write, an
// object slot, start of frame, or nothing. writes, frame starts and slots
// outside the active list range leave the walker idle. a slot reads its
// 4-byte header in two ram reads; an empty or rejected entry then returns
// to idle. a live entry fetches one 16-bit tile word per cycle from the ram
// port while the output is not stalled and issues one draw word per tile:
// 4 tiles for a sprite, 64 for a column; the single ram read port sets this
// rate. an accepted slot passes hdr0, hdr1 and the tile fetch state, then
// the output register, before its first draw word. output words
// (out_valid / out_stall) leave through an output register; a stall holds
// the word and pauses the tile fetch, and a new input word is taken while
// the last draw word of an entry is still waiting. config words (cfg_valid
// / cfg_ready, always ready) set layout mode and char bank; write them only while idle.
// reset clears state, column x, config and output valid; ram is undefined
// until written.
// ---------------------------------------------------------------------------
module column_sprite_list_walker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  action,
  input  logic [cswl_pkg::ADDR_W-1:0] address,
  input  logic [7:0]                  write_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [7:0]                  cfg_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [12:0]                 tile_code,
  output logic [3:0]                  palette,
  output logic                        flip_x,
  output logic [7:0]                  pos_x,
  output logic [7:0]                  pos_y,
  output logic                        last
);

  cswl_pkg::ram_req_t ram_req;
  logic [7:0]         rd_lo;
  logic [7:0]         rd_hi;

  assign cfg_ready = 1'b1;

  cswl_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rd_lo (rd_lo),
    .rd_hi (rd_hi)
  );

  cswl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .address    (address),
    .write_data (write_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tile_code  (tile_code),
    .palette    (palette),
    .flip_x     (flip_x),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .last       (last),
    .ram_req    (ram_req),
    .rd_lo      (rd_lo),
    .rd_hi      (rd_hi)
  );

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for column_sprite_list_walker: one tile region and a
// set of entries are written, directed slots walked, then random traffic
// ---------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 500000;

  // every entry points its tiles into this one written region
  localparam logic [4:0] TILE_GFX  = 5'd3;
  localparam int         TILE_BASE = int'(TILE_GFX) * 128;

  typedef struct {
    cswl_pkg::action_t           act;
    logic [cswl_pkg::ADDR_W-1:0] adr;
    logic [7:0]                  dat;
  } word_t;

  typedef struct packed {
    logic [12:0] code;
    logic [3:0]  pal;
    logic        flip;
    logic [7:0]  px;
    logic [7:0]  py;
    logic        fin;
  } draw_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [1:0]                  action = 2'd0;
  logic [cswl_pkg::ADDR_W-1:0] address = '0;
  logic [7:0]                  write_data = 8'd0;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic                        cfg_index = 1'b0;
  logic [7:0]                  cfg_data = 8'd0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [12:0]                 tile_code;
  logic [3:0]                  palette;
  logic                        flip_x;
  logic [7:0]                  pos_x;
  logic [7:0]                  pos_y;
  logic                        last;

  word_t      stim_q[$];
  draw_t      draw_q[$];
  int         live_q[$];
  logic [7:0] obj_mem [cswl_pkg::RAM_BYTES];
  logic [7:0] col_x = 8'd0;
  logic       cur_layout = 1'b0;
  logic       cur_bank = 1'b0;
  logic       in_took = 1'b0;
  bit         quiet = 1'b0;
  int         errors = 0;
  int         cycles = 0;

  column_sprite_list_walker u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .address    (address),
    .write_data (write_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tile_code  (tile_code),
    .palette    (palette),
    .flip_x     (flip_x),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .last       (last)
  );

  always #5 clk = ~clk;

  function automatic bit take_break();
    return !quiet && ($urandom_range(99) < 22);
  endfunction

  task automatic push_word(input cswl_pkg::action_t a, input int adr, input int dat);
    word_t w;
    w.act = a;
    w.adr = cswl_pkg::ADDR_W'(adr);
    w.dat = 8'(dat);
    stim_q.push_back(w);
  endtask

  // walk one accepted word and queue the draw words it produces
  task automatic apply_word(input word_t w);
    logic [cswl_pkg::ADDR_W-1:0] ent, base, wa;
    logic [7:0]                  y0, gn, x0, at, lo, hi, sy;
    int                          rows, h, r, k;
    draw_t                       d;
    case (w.act)
      cswl_pkg::ACT_WRITE: obj_mem[w.adr] = w.dat;
      cswl_pkg::ACT_FRAME: col_x = 8'd0;
      cswl_pkg::ACT_SLOT: begin
        ent = {w.adr[cswl_pkg::ADDR_W-1:2], 2'b00};
        if (ent < cswl_pkg::LIST_START) return;
        if (!cur_layout && ((ent >= cswl_pkg::LIST_GAP_START &&
                             ent < cswl_pkg::LIST_GAP_END) ||
                            ent >= cswl_pkg::LIST_END)) return;
        if (cur_layout && ent >= cswl_pkg::LIST_GAP_START) return;
        y0 = obj_mem[ent];
        gn = obj_mem[ent + 1];
        x0 = obj_mem[ent + 2];
        at = obj_mem[ent + 3];
        if ({y0, gn, x0, at} == 32'd0) return;
        if (gn[7]) begin
          base = {gn[5:0], 7'd0};
          rows = 32;
        end else begin
          if (cur_layout && (y0 == 8'd0 || x0 == 8'd0)) return;
          base = {1'b0, gn[4:0], 7'd0} + cswl_pkg::ADDR_W'(gn[6:5] * 16) +
                 cswl_pkg::ADDR_W'(12);
          rows = 2;
        end
        col_x = (gn[7:6] == 2'b11) ? col_x + cswl_pkg::COLUMN_STEP : x0;
        sy = 8'd0 - 8'(rows * 8) - y0;
        for (k = 0; k < 2 * rows; k++) begin
          if (cur_layout) begin
            r = k / 2;
            h = k % 2;
          end else begin
            h = k / rows;
            r = k % rows;
          end
          wa = base + cswl_pkg::ADDR_W'(h * 64 + r * 2);
          lo = obj_mem[wa];
          hi = obj_mem[wa + 1];
          if (cur_layout) begin
            d.code = {hi[4:0], lo};
            d.pal  = {1'b0, hi[7:5]};
            d.flip = 1'b0;
          end else begin
            d.code = {cur_bank, hi[7], hi[2:0], lo};
            d.pal  = {at[1], hi[5:3]};
            d.flip = hi[6];
          end
          d.px  = col_x + 8'(h * 8);
          d.py  = sy + 8'(r * 8);
          d.fin = (k == 2 * rows - 1);
          draw_q.push_back(d);
        end
      end
      default: ;
    endcase
  endtask

  always @(negedge clk) begin : drive
    word_t w;
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= take_break();
      if (!in_valid || in_took) begin
        if (stim_q.size() != 0 && !take_break()) begin
          w = stim_q.pop_front();
          in_valid   <= 1'b1;
          action     <= w.act;
          address    <= w.adr;
          write_data <= w.dat;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    draw_t e;
    word_t w;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (draw_q.size() == 0) begin
          $error("draw word with nothing expected, tile_code %0h", tile_code);
          errors++;
        end else begin
          e = draw_q.pop_front();
          if (tile_code !== e.code) begin
            $error("tile_code: expected %0h, got %0h", e.code, tile_code);
            errors++;
          end
          if (palette !== e.pal) begin
            $error("palette: expected %0h, got %0h", e.pal, palette);
            errors++;
          end
          if (flip_x !== e.flip) begin
            $error("flip_x: expected %0h, got %0h", e.flip, flip_x);
            errors++;
          end
          if (pos_x !== e.px) begin
            $error("pos_x: expected %0h, got %0h", e.px, pos_x);
            errors++;
          end
          if (pos_y !== e.py) begin
            $error("pos_y: expected %0h, got %0h", e.py, pos_y);
            errors++;
          end
          if (last !== e.fin) begin
            $error("last: expected %0h, got %0h", e.fin, last);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        w.act = cswl_pkg::action_t'(action);
        w.adr = address;
        w.dat = write_data;
        apply_word(w);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cswl_pkg::CFG_LAYOUT_MODE) begin
          cur_layout = cfg_data[0];
        end else begin
          cur_bank = cfg_data[0];
        end
      end
    end
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("FAIL column_sprite_list_walker");
    $finish;
  end

  task automatic write_reg(input cswl_pkg::cfg_index_t idx, input logic val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= {7'($urandom), val};
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle(input int tail);
    while (stim_q.size() != 0 || in_valid || draw_q.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic load_entry(input int ent, input logic [31:0] b);
    push_word(cswl_pkg::ACT_WRITE, ent, b[31:24]);
    push_word(cswl_pkg::ACT_WRITE, ent + 1, b[23:16]);
    push_word(cswl_pkg::ACT_WRITE, ent + 2, b[15:8]);
    push_word(cswl_pkg::ACT_WRITE, ent + 3, b[7:0]);
    live_q.push_back(ent);
  endtask

  function automatic int pick_entry(input bit m);
    if (!m && $urandom_range(3) == 0) return cswl_pkg::LIST_GAP_END + 4 * $urandom_range(15);
    return cswl_pkg::LIST_START + 4 * $urandom_range(191);
  endfunction

  task automatic add_random_words(input int n, input bit m);
    int         cnt, pick, ent, reps, j, adr;
    logic [7:0] y, g, x, at;
    cnt = 0;
    while (cnt < n) begin
      pick = $urandom_range(99);
      ent  = pick_entry(m);
      y    = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom);
      x    = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom);
      at   = 8'($urandom);
      case ($urandom_range(9))
        0, 1, 2, 3: g = {1'b0, 2'($urandom), TILE_GFX};
        4, 5:       g = {3'b100, TILE_GFX};
        default:    g = {3'b110, TILE_GFX};
      endcase
      if (pick < 45) begin
        if ($urandom_range(9) == 0) begin
          y  = 8'd0;
          g  = 8'd0;
          x  = 8'd0;
          at = 8'd0;
        end
        load_entry(ent, {y, g, x, at});
        push_word(cswl_pkg::ACT_SLOT, ent + $urandom_range(3), $urandom);
        cnt += 5;
      end else if (pick < 52) begin
        // chain of 2 to 17 following columns, which can wrap column x
        reps = $urandom_range(2, 17);
        load_entry(ent, {y, 3'b110, TILE_GFX, x, at});
        for (j = 0; j < reps; j++) begin
          push_word(cswl_pkg::ACT_SLOT, ent + $urandom_range(3), $urandom);
        end
        cnt += 4 + reps;
      end else if (pick < 67) begin
        ent = live_q[$urandom_range(live_q.size() - 1)];
        push_word(cswl_pkg::ACT_SLOT, ent + $urandom_range(3), $urandom);
        cnt++;
      end else if (pick < 75) begin
        push_word(cswl_pkg::ACT_FRAME, $urandom, $urandom);
        cnt++;
      end else if (pick < 85) begin
        push_word(cswl_pkg::ACT_WRITE, $urandom_range(cswl_pkg::LIST_START - 1), $urandom);
        cnt++;
      end else begin
        if ($urandom_range(1) == 0) begin
          push_word(cswl_pkg::ACT_NONE, $urandom, $urandom);
        end else begin
          case ($urandom_range(2))
            0:       adr = $urandom_range(0, cswl_pkg::LIST_START - 1);
            1:       adr = m ? $urandom_range(cswl_pkg::LIST_GAP_START,
                                              cswl_pkg::RAM_BYTES - 1)
                             : $urandom_range(cswl_pkg::LIST_GAP_START,
                                              cswl_pkg::LIST_GAP_END - 1);
            default: adr = m ? $urandom_range(cswl_pkg::LIST_GAP_START,
                                              cswl_pkg::RAM_BYTES - 1)
                             : $urandom_range(cswl_pkg::LIST_END,
                                              cswl_pkg::RAM_BYTES - 1);
          endcase
          push_word(cswl_pkg::ACT_SLOT, adr, $urandom);
        end
        cnt++;
      end
    end
  endtask

  initial begin : run
    int a;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(cswl_pkg::CFG_LAYOUT_MODE, 1'b0);
    write_reg(cswl_pkg::CFG_CHAR_BANK, 1'b1);

    for (a = 0; a < 128; a++) push_word(cswl_pkg::ACT_WRITE, TILE_BASE + a, $urandom);
    load_entry('h1500, 32'h00_03_ff_02);
    load_entry('h1504, 32'hff_63_00_fd);
    load_entry('h1508, 32'h10_83_20_00);
    load_entry('h150c, 32'h10_c3_00_ff);
    load_entry('h1510, 32'h00_00_00_00);
    load_entry('h1514, 32'h00_43_30_00);
    load_entry('h1518, 32'h20_23_00_01);
    load_entry('h151c, 32'h7f_63_7f_04);
    load_entry('h17fc, 32'h40_c3_80_00);
    load_entry('h1980, 32'hf0_83_e8_02);
    load_entry('h19bc, 32'h08_c3_00_02);

    push_word(cswl_pkg::ACT_FRAME, 0, 0);
    push_word(cswl_pkg::ACT_SLOT, 'h1500, 0);
    push_word(cswl_pkg::ACT_SLOT, 'h1505, 'hff);
    push_word(cswl_pkg::ACT_SLOT, 'h150a, 0);
    push_word(cswl_pkg::ACT_SLOT, 'h150f, 0);
    push_word(cswl_pkg::ACT_SLOT, 'h1510, 0);
    push_word(cswl_pkg::ACT_SLOT, 'h1514, 0);
    push_word(cswl_pkg::ACT_SLOT, 'h1518, 0);
    push_word(cswl_pkg::ACT_SLOT, 'h17fe, 0);
    push_word(cswl_pkg::ACT_SLOT, 'h1980, 0);
    push_word(cswl_pkg::ACT_SLOT, 'h19bd, 0);
    push_word(cswl_pkg::ACT_SLOT, 'h0000, 0);
    push_word(cswl_pkg::ACT_SLOT, 'h14fc, 0);
    push_word(cswl_pkg::ACT_SLOT, 'h1800, 0);
    push_word(cswl_pkg::ACT_SLOT, 'h19c0, 0);
    push_word(cswl_pkg::ACT_NONE, 'h1500, 'hff);
    push_word(cswl_pkg::ACT_FRAME, 'h1fff, 'hff);
    push_word(cswl_pkg::ACT_SLOT, 'h150c, 0);
    settle(8);

    write_reg(cswl_pkg::CFG_LAYOUT_MODE, 1'b1);
    push_word(cswl_pkg::ACT_FRAME, 0, 0);
    push_word(cswl_pkg::ACT_SLOT, 'h1508, 0);
    push_word(cswl_pkg::ACT_SLOT, 'h150c, 0);
    push_word(cswl_pkg::ACT_SLOT, 'h151c, 0);
    push_word(cswl_pkg::ACT_SLOT, 'h1514, 0);
    push_word(cswl_pkg::ACT_SLOT, 'h1518, 0);
    push_word(cswl_pkg::ACT_SLOT, 'h17fc, 0);
    push_word(cswl_pkg::ACT_SLOT, 'h1800, 0);
    push_word(cswl_pkg::ACT_SLOT, 'h1980, 0);
    add_random_words(70, 1'b1);
    settle(8);

    write_reg(cswl_pkg::CFG_LAYOUT_MODE, 1'b0);
    write_reg(cswl_pkg::CFG_CHAR_BANK, 1'b0);
    quiet = 1'b1;
    add_random_words(70, 1'b0);
    settle(8);
    quiet = 1'b0;

    write_reg(cswl_pkg::CFG_LAYOUT_MODE, 1'b1);
    add_random_words(70, 1'b1);
    settle(8);

    write_reg(cswl_pkg::CFG_LAYOUT_MODE, 1'b0);
    write_reg(cswl_pkg::CFG_CHAR_BANK, 1'b1);
    add_random_words(70, 1'b0);
    settle(70);

    if (errors == 0) begin
      $display("PASS column_sprite_list_walker");
    end else begin
      $display("FAIL column_sprite_list_walker");
    end
    $finish;
  end

endmodule

### sim.f
design/cswl_pkg.sv
design/cswl_ram.sv
design/cswl_ctrl.sv
design/column_sprite_list_walker.sv
dv/tb.sv
